[rtl/core/ir_beacon_pulse_decoder_macros.svh]
// ----------------------------------------------------------------------------
// IR beacon pulse decoder assertion macros
// Shared assertion forms used by the decoder's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef IR_BEACON_PULSE_DECODER_MACROS_SVH
`define IR_BEACON_PULSE_DECODER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IRBPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IRBPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/irbpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR beacon pulse decoder package
// Request codes, register indexes, pulse timing limits and shared types.
// ----------------------------------------------------------------------------
package irbpd_pkg;

   // Request codes carried by req_type.
   localparam logic [1:0] REQ_EDGE     = 2'd0;
   localparam logic [1:0] REQ_OVERFLOW = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CODE_LEFT   = 2'd0;
   localparam logic [1:0] CSR_CODE_CENTER = 2'd1;
   localparam logic [1:0] CSR_CODE_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_HOLD_TICKS  = 2'd3;

   // Pulse timing limits in 10 us units; all ranges are exclusive.
   localparam logic [32:0] LEADER_LOW_MIN  = 33'd700;
   localparam logic [32:0] LEADER_LOW_MAX  = 33'd1100;
   localparam logic [32:0] LEADER_HIGH_MIN = 33'd313;
   localparam logic [32:0] LEADER_HIGH_MAX = 33'd600;
   localparam logic [32:0] MARK_MIN        = 33'd10;
   localparam logic [32:0] MARK_MAX        = 33'd100;
   localparam logic [32:0] ZERO_CELL_MIN   = 33'd92;
   localparam logic [32:0] ZERO_CELL_MAX   = 33'd132;
   localparam logic [32:0] ONE_CELL_MIN    = 33'd205;
   localparam logic [32:0] ONE_CELL_MAX    = 33'd245;
   localparam logic [32:0] GAP_MIN         = 33'd5000;

   // Bits in one beacon byte, and overflow events that reset a channel.
   localparam logic [3:0] BYTE_BITS      = 4'd8;
   localparam logic [1:0] OVERFLOW_LIMIT = 2'd2;

   // Number of beacon sites per channel.
   localparam int SITES = 3;

   // Decoder phase of one channel.
   typedef enum logic [1:0] {
      PH_LEADER_LOW  = 2'd0,
      PH_LEADER_HIGH = 2'd1,
      PH_MARK        = 2'd2,
      PH_SPACE       = 2'd3
   } phase_type;

   // Configuration register contents.
   typedef struct packed {
      logic [7:0]  code_left;
      logic [7:0]  code_center;
      logic [7:0]  code_right;
      logic [15:0] hold_ticks;
   } cfg_type;

   // Event strobes for one channel, active in the cycle a transaction commits.
   typedef struct packed {
      logic edge_en;
      logic overflow_en;
      logic tick_en;
   } chan_event_type;

   // Next status of one channel after the committing transaction.
   typedef struct packed {
      logic [2:0] presence;
      logic       falling;
      logic       code_valid;
      logic [7:0] code_value;
   } chan_status_type;

endpackage

[rtl/core/irbpd_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR beacon pulse decoder configuration registers
// Holds the three beacon codes and the presence hold time.
// ----------------------------------------------------------------------------
module irbpd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output irbpd_pkg::cfg_type   cfg
);
   import irbpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always accepted.
   assign csr_ready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CODE_LEFT:   cfg_in.code_left   = csr_data[7:0];
            CSR_CODE_CENTER: cfg_in.code_center = csr_data[7:0];
            CSR_CODE_RIGHT:  cfg_in.code_right  = csr_data[7:0];
            CSR_HOLD_TICKS:  cfg_in.hold_ticks  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Register storage with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_left   <= 8'd1;
         cfg_ff.code_center <= 8'd2;
         cfg_ff.code_right  <= 8'd3;
         cfg_ff.hold_ticks  <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/irbpd_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR beacon pulse decoder channel
// Pulse width, leader and bit-cell decoding, code match, presence hold.
// ----------------------------------------------------------------------------
module irbpd_chan #(
   parameter int CAPTURE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  irbpd_pkg::chan_event_type    ev,
   input  logic [CAPTURE_BITS-1:0]      now,
   input  irbpd_pkg::cfg_type           cfg,
   output irbpd_pkg::chan_status_type   status
);
   import irbpd_pkg::*;

   localparam logic [CAPTURE_BITS-1:0] CAP_MASK = {CAPTURE_BITS{1'b1}};

   // Channel state.
   phase_type               phase_ff, phase_in;
   logic [7:0]              sb_ff, sb_in;
   logic [3:0]              bc_ff, bc_in;
   logic [6:0]              mark_ff, mark_in;
   logic [CAPTURE_BITS-1:0] last_ff, last_in;
   logic                    fall_ff, fall_in;
   logic [1:0]              ovf_ff, ovf_in;
   logic [2:0]              filt_ff, filt_in;
   logic [2:0]              pres_ff, pres_in;
   logic [15:0]             hold_ff [SITES];
   logic [15:0]             hold_in [SITES];
   logic [15:0]             hold_inc [SITES];

   // Derived values.
   logic [CAPTURE_BITS-1:0] width;
   logic [32:0]             w_x;
   logic [32:0]             total;
   logic                    first_capture;
   logic                    is_leader;
   logic                    is_gap;
   logic                    leader_high_ok;
   logic                    mark_ok;
   logic                    bit_zero;
   logic                    bit_one;
   logic [7:0]              sb_shift;
   logic [3:0]              bc_next;
   logic                    rejudge;
   logic                    byte_done;

   // Pulse width since the previous edge, wrapping at the capture counter.
   always_comb begin
      if (now >= last_ff) begin
         width = now - last_ff;
      end else begin
         width = (CAP_MASK - last_ff) + now;
      end
   end

   assign w_x   = 33'(width);
   assign total = 33'(mark_ff) + w_x;

   assign first_capture  = (phase_ff == PH_LEADER_LOW) && (last_ff == '0);
   assign is_leader      = (w_x > LEADER_LOW_MIN) && (w_x < LEADER_LOW_MAX);
   assign is_gap         = (w_x > GAP_MIN);
   assign leader_high_ok = (w_x > LEADER_HIGH_MIN) && (w_x < LEADER_HIGH_MAX);
   assign mark_ok        = (w_x > MARK_MIN) && (w_x < MARK_MAX);
   assign bit_zero       = (total > ZERO_CELL_MIN) && (total < ZERO_CELL_MAX);
   assign bit_one        = (total > ONE_CELL_MIN) && (total < ONE_CELL_MAX);
   assign sb_shift       = {sb_ff[6:0], bit_one};
   assign bc_next        = bc_ff + 4'd1;
   assign byte_done      = (bit_zero || bit_one) && (bc_next == BYTE_BITS);

   // Hold counter increments, one per site.
   always_comb begin
      for (int s = 0; s < SITES; s++) begin
         hold_inc[s] = hold_ff[s] + 16'd1;
      end
   end

   // Next state of the decoder, overflow handling and presence hold.
   always_comb begin
      phase_in = phase_ff;
      sb_in    = sb_ff;
      bc_in    = bc_ff;
      mark_in  = mark_ff;
      last_in  = last_ff;
      fall_in  = fall_ff;
      ovf_in   = ovf_ff;
      filt_in  = filt_ff;
      pres_in  = pres_ff;
      rejudge  = 1'b0;
      for (int s = 0; s < SITES; s++) begin
         hold_in[s] = hold_ff[s];
      end

      if (ev.edge_en) begin
         ovf_in  = '0;
         fall_in = ~fall_ff;
         last_in = now;
         if (!first_capture) begin
            case (phase_ff)
               PH_LEADER_LOW: begin
                  rejudge = 1'b1;
               end
               PH_LEADER_HIGH: begin
                  phase_in = leader_high_ok ? PH_MARK : PH_LEADER_LOW;
               end
               PH_MARK: begin
                  if (mark_ok) begin
                     phase_in = PH_SPACE;
                     mark_in  = width[6:0];
                  end else begin
                     rejudge = 1'b1;
                  end
               end
               PH_SPACE: begin
                  if (bit_zero || bit_one) begin
                     bc_in = bc_next;
                     if (byte_done) begin
                        // First matching code wins: left, then center, then right.
                        sb_in    = '0;
                        phase_in = PH_LEADER_LOW;
                        if (sb_shift == cfg.code_left) begin
                           filt_in = filt_ff | 3'b001;
                        end else if (sb_shift == cfg.code_center) begin
                           filt_in = filt_ff | 3'b010;
                        end else if (sb_shift == cfg.code_right) begin
                           filt_in = filt_ff | 3'b100;
                        end
                     end else begin
                        sb_in    = sb_shift;
                        phase_in = PH_MARK;
                     end
                  end else begin
                     // A bad cell still leaves the byte shifted by one, unless re-judged as a leader.
                     sb_in   = sb_shift;
                     rejudge = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_LEADER_LOW;
               end
            endcase

            // Idle judgement of the width: a leader starts a frame, a long gap
            // publishes the filter flags as presence.
            if (rejudge) begin
               phase_in = PH_LEADER_LOW;
               if (is_leader) begin
                  phase_in = PH_LEADER_HIGH;
                  sb_in    = '0;
                  bc_in    = '0;
               end else if (is_gap) begin
                  pres_in = filt_ff;
                  filt_in = '0;
               end
            end
         end
      end else if (ev.overflow_en) begin
         if (ovf_ff < OVERFLOW_LIMIT) begin
            ovf_in = ovf_ff + 2'd1;
            if (ovf_in == OVERFLOW_LIMIT) begin
               fall_in  = 1'b1;
               phase_in = PH_LEADER_LOW;
               pres_in  = '0;
               filt_in  = '0;
            end
         end
      end else if (ev.tick_en) begin
         for (int s = 0; s < SITES; s++) begin
            if (pres_ff[s]) begin
               if (hold_inc[s] >= cfg.hold_ticks) begin
                  hold_in[s] = '0;
                  pres_in[s] = 1'b0;
               end else begin
                  hold_in[s] = hold_inc[s];
               end
            end else begin
               hold_in[s] = '0;
            end
         end
      end
   end

   // Status toward the result register.
   always_comb begin
      status.presence   = pres_in;
      status.falling    = fall_in;
      status.code_valid = ev.edge_en && !first_capture && (phase_ff == PH_SPACE) && byte_done;
      status.code_value = status.code_valid ? sb_shift : 8'd0;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEADER_LOW;
         sb_ff    <= '0;
         bc_ff    <= '0;
         mark_ff  <= '0;
         last_ff  <= '0;
         fall_ff  <= 1'b1;
         ovf_ff   <= '0;
         filt_ff  <= '0;
         pres_ff  <= '0;
         for (int s = 0; s < SITES; s++) begin
            hold_ff[s] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         sb_ff    <= sb_in;
         bc_ff    <= bc_in;
         mark_ff  <= mark_in;
         last_ff  <= last_in;
         fall_ff  <= fall_in;
         ovf_ff   <= ovf_in;
         filt_ff  <= filt_in;
         pres_ff  <= pres_in;
         for (int s = 0; s < SITES; s++) begin
            hold_ff[s] <= hold_in[s];
         end
      end
   end

endmodule

[rtl/core/ir_beacon_pulse_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR beacon pulse decoder
// Multi-channel NEC-style infrared beacon decoder with presence hold.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one event per transaction: a capture edge with its
// channel and timestamp, a capture counter overflow, or a millisecond tick.
// The rsp channel returns exactly one transaction per request: the presence
// flags of every channel and site, the expected polarity of each channel's
// next edge, and the byte of a code completed by this request, if any.
// The csr channel writes the beacon codes and the hold time; it is always
// ready and must only be used while the block is idle.
// A request passes through the input register and then the result register
// before its response is valid. Throughput: one request per cycle while
// responses are taken, set by the update of the per-channel state in the
// cycle a request commits.
// When rsp_ready is low the response is held and one further request is
// taken into the input register; req_ready then drops until the response
// is taken. Reset empties both registers, clears all channel state, sets
// every channel to expect a falling edge and loads default register values.
// ----------------------------------------------------------------------------
`include "ir_beacon_pulse_decoder_macros.svh"

module ir_beacon_pulse_decoder #(
   parameter int CHANNELS     = 4,
   parameter int CAPTURE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_type,
   input  logic [1:0]              req_channel,
   input  logic [15:0]             req_capture_time,
   // Response channel.
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3*CHANNELS-1:0]   rsp_present_flags,
   output logic [CHANNELS-1:0]     rsp_wait_falling,
   output logic                    rsp_code_valid,
   output logic [7:0]              rsp_code_value,
   // Configuration channel.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data
);
   import irbpd_pkg::*;

   // Input register.
   logic                    in_valid_ff;
   logic [1:0]              in_req_ff;
   logic [1:0]              in_chan_ff;
   logic [15:0]             in_time_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic [3*CHANNELS-1:0]   rsp_flags_ff;
   logic [CHANNELS-1:0]     rsp_fall_ff;
   logic                    rsp_code_valid_ff;
   logic [7:0]              rsp_code_value_ff;

   logic                    advance;
   logic [CAPTURE_BITS-1:0] now;
   logic [3*CHANNELS-1:0]   flags_next;
   logic [CHANNELS-1:0]     fall_next;
   logic                    code_valid_next;
   logic [7:0]              code_value_next;
   cfg_type                 cfg;
   chan_event_type          ev     [CHANNELS];
   chan_status_type         status [CHANNELS];

   // The input transaction commits when the result register is free or
   // being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign now       = CAPTURE_BITS'(in_time_ff);

   // Configuration registers.
   irbpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Per-channel decoders.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      always_comb begin
         ev[c].edge_en     = advance && (in_req_ff == REQ_EDGE)
                             && (4'(in_chan_ff) == 4'(c));
         ev[c].overflow_en = advance && (in_req_ff == REQ_OVERFLOW);
         ev[c].tick_en     = advance && (in_req_ff == REQ_TICK);
      end

      irbpd_chan #(
         .CAPTURE_BITS (CAPTURE_BITS)
      ) u_chan (
         .clock  (clock),
         .reset  (reset),
         .ev     (ev[c]),
         .now    (now),
         .cfg    (cfg),
         .status (status[c])
      );

      assign flags_next[3*c +: 3] = status[c].presence;
      assign fall_next[c]         = status[c].falling;
   end

   // At most one channel completes a code per transaction.
   always_comb begin
      code_valid_next = 1'b0;
      code_value_next = 8'd0;
      for (int c = 0; c < CHANNELS; c++) begin
         code_valid_next = code_valid_next | status[c].code_valid;
         code_value_next = code_value_next | status[c].code_value;
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff  <= req_type;
         in_chan_ff <= req_channel;
         in_time_ff <= req_capture_time;
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flags_ff      <= flags_next;
         rsp_fall_ff       <= fall_next;
         rsp_code_valid_ff <= code_valid_next;
         rsp_code_value_ff <= code_value_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_present_flags = rsp_flags_ff;
   assign rsp_wait_falling  = rsp_fall_ff;
   assign rsp_code_valid    = rsp_code_valid_ff;
   assign rsp_code_value    = rsp_code_value_ff;

   // Checks on the pipeline and the result contents.
   `IRBPD_ASSERT_NOW(a_code_zero_when_none, clock, reset, rsp_valid && !rsp_code_valid, rsp_code_value == 8'd0, "code byte set without a completed code")
   `IRBPD_ASSERT_NEXT(a_held_input_kept, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready, in_valid_ff, "pending transaction lost while the response stalls")
   `IRBPD_ASSERT_NEXT(a_code_only_on_edge, clock, reset, advance && (in_req_ff != REQ_EDGE), !rsp_code_valid, "code reported for a non-edge transaction")
   `IRBPD_ASSERT_NOW(a_stall_means_full, clock, reset, !req_ready, in_valid_ff && rsp_valid_ff, "request stalled with a free stage")

endmodule

[dv/ir_beacon_pulse_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR beacon pulse decoder testbench
// Drives capture edges, counter overflows and millisecond ticks through the
// request handshake. A cycle-free model of the per-channel NEC decoder,
// beacon filter and presence hold predicts every response, and each response
// is compared field by field. A short directed table covers first captures,
// counter wrap, repeat leaders, re-judged marks and cells, overflow reset and
// unused requests. Random NEC frames with noise follow under several register
// settings, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module ir_beacon_pulse_decoder_tb;
   import irbpd_pkg::*;

   localparam int          CLK_PERIOD    = 12;
   localparam int          NUM_CH        = 4;
   localparam logic [1:0]  REQ_UNUSED    = 2'd3;
   localparam logic [15:0] CAPTURE_ONES  = 16'hFFFF;
   localparam int          MAX_PRINTS    = 20;
   localparam int          SETTLE_CYCLES = 8;

   // One response of the block.
   typedef struct packed {
      logic [3*NUM_CH-1:0] flags;
      logic [NUM_CH-1:0]   wait_fall;
      logic                code_valid;
      logic [7:0]          code_value;
   } beacon_status_type;

   // One row of the directed table; fixed rows carry their own response.
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        ch;
      logic [15:0]       stamp;
      logic              fixed;
      beacon_status_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type = REQ_EDGE;
   logic [1:0]            req_channel = 2'd0;
   logic [15:0]           req_capture_time = 16'd0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [3*NUM_CH-1:0]   rsp_present_flags;
   logic [NUM_CH-1:0]     rsp_wait_falling;
   logic                  rsp_code_valid;
   logic [7:0]            rsp_code_value;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = CSR_CODE_LEFT;
   logic [15:0]           csr_data = 16'd0;

   // Model state of the decoder, one entry per channel or per channel and site.
   cfg_type     cfg;
   phase_type   dec_phase [NUM_CH];
   logic [7:0]  shift_reg [NUM_CH];
   logic [3:0]  bits_done [NUM_CH];
   logic [6:0]  mark_len  [NUM_CH];
   logic [15:0] last_stamp [NUM_CH];
   logic        fall_next [NUM_CH];
   logic [1:0]  ovf_seen  [NUM_CH];
   logic [2:0]  filter    [NUM_CH];
   logic [2:0]  presence  [NUM_CH];
   logic [15:0] hold_cnt  [NUM_CH*SITES];

   // Stimulus bookkeeping.
   logic [15:0]       chan_now [NUM_CH];
   beacon_status_type beacon_status_q [$];
   bit                idle_on = 1'b1;
   int unsigned       mismatch_count = 0;
   int unsigned       sent_items = 0;
   int unsigned       checked_count = 0;
   int unsigned       bytes_seen = 0;
   int unsigned       settings_count = 1;

   stim_row_type directed_rows [22] = '{
      // First capture at the top of the counter: stored only.
      '{REQ_EDGE,     2'd0, 16'd65535, 1'b1, '{12'h000, 4'b1110, 1'b0, 8'h00}},
      // Width across the counter wrap is a leader low.
      '{REQ_EDGE,     2'd0, 16'd900,   1'b0, '0},
      // Repeat-code leader high is rejected.
      '{REQ_EDGE,     2'd0, 16'd1125,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd2025,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd2475,  1'b0, '0},
      // A bad mark is judged again as a new leader low.
      '{REQ_EDGE,     2'd0, 16'd3275,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd3725,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd3775,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd3935,  1'b0, '0},
      '{REQ_EDGE,     2'd0, 16'd3985,  1'b0, '0},
      // A bad bit cell is judged again as a long gap.
      '{REQ_EDGE,     2'd0, 16'd9035,  1'b0, '0},
      // First capture at zero keeps the channel in first-capture mode.
      '{REQ_EDGE,     2'd1, 16'd0,     1'b0, '0},
      '{REQ_OVERFLOW, 2'd2, 16'd4321,  1'b0, '0},
      // Second overflow without an edge resets every channel.
      '{REQ_OVERFLOW, 2'd3, 16'd0,     1'b1, '{12'h000, 4'b1111, 1'b0, 8'h00}},
      '{REQ_TICK,     2'd1, 16'd65535, 1'b0, '0},
      // Unused request code changes nothing.
      '{REQ_UNUSED,   2'd3, 16'hFFFF,  1'b1, '{12'h000, 4'b1111, 1'b0, 8'h00}},
      '{REQ_EDGE,     2'd2, 16'd40000, 1'b0, '0},
      '{REQ_EDGE,     2'd3, 16'd12345, 1'b0, '0},
      '{REQ_EDGE,     2'd2, 16'd40850, 1'b0, '0},
      '{REQ_EDGE,     2'd2, 16'd41330, 1'b0, '0},
      '{REQ_EDGE,     2'd2, 16'd41360, 1'b0, '0},
      '{REQ_EDGE,     2'd2, 16'd41440, 1'b0, '0}
   };

   ir_beacon_pulse_decoder #(
      .CHANNELS     (NUM_CH),
      .CAPTURE_BITS (16)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_capture_time  (req_capture_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_present_flags (rsp_present_flags),
      .rsp_wait_falling  (rsp_wait_falling),
      .rsp_code_valid    (rsp_code_valid),
      .rsp_code_value    (rsp_code_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Put the model into its power-on state.
   function automatic void clear_model();
      cfg.code_left   = 8'd1;
      cfg.code_center = 8'd2;
      cfg.code_right  = 8'd3;
      cfg.hold_ticks  = 16'd1000;
      for (int c = 0; c < NUM_CH; c++) begin
         dec_phase[c]  = PH_LEADER_LOW;
         shift_reg[c]  = 8'd0;
         bits_done[c]  = 4'd0;
         mark_len[c]   = 7'd0;
         last_stamp[c] = 16'd0;
         fall_next[c]  = 1'b1;
         ovf_seen[c]   = 2'd0;
         filter[c]     = 3'd0;
         presence[c]   = 3'd0;
         chan_now[c]   = 16'd0;
      end
      for (int k = 0; k < NUM_CH * SITES; k++) hold_cnt[k] = 16'd0;
   endfunction

   // Run one pulse width through a channel's decoder. A rejected mark or cell
   // sends the decoder back to the leader phase, which judges the same width.
   function automatic void decode_pulse(input int c, input logic [32:0] w,
                                        output logic done, output logic [7:0] code);
      logic        again;
      logic [32:0] total;
      done = 1'b0;
      code = 8'd0;
      do begin
         again = 1'b0;
         case (dec_phase[c])
            PH_LEADER_LOW: begin
               if (w > LEADER_LOW_MIN && w < LEADER_LOW_MAX) begin
                  dec_phase[c] = PH_LEADER_HIGH;
                  shift_reg[c] = 8'd0;
                  bits_done[c] = 4'd0;
               end else if (w > GAP_MIN) begin
                  presence[c] = filter[c];
                  filter[c]   = 3'd0;
               end
            end
            PH_LEADER_HIGH: begin
               dec_phase[c] = (w > LEADER_HIGH_MIN && w < LEADER_HIGH_MAX) ?
                              PH_MARK : PH_LEADER_LOW;
            end
            PH_MARK: begin
               if (w > MARK_MIN && w < MARK_MAX) begin
                  dec_phase[c] = PH_SPACE;
                  mark_len[c]  = w[6:0];
               end else begin
                  dec_phase[c] = PH_LEADER_LOW;
                  again = 1'b1;
               end
            end
            default: begin
               total = {26'd0, mark_len[c]} + w;
               shift_reg[c] = shift_reg[c] << 1;
               if (total > ONE_CELL_MIN && total < ONE_CELL_MAX) begin
                  shift_reg[c][0] = 1'b1;
               end else if (!(total > ZERO_CELL_MIN && total < ZERO_CELL_MAX)) begin
                  dec_phase[c] = PH_LEADER_LOW;
                  again = 1'b1;
               end
               if (!again) begin
                  bits_done[c] = bits_done[c] + 4'd1;
                  if (bits_done[c] == BYTE_BITS) begin
                     code = shift_reg[c];
                     shift_reg[c] = 8'd0;
                     // Only the first matching site counts.
                     if (code == cfg.code_left) filter[c][0] = 1'b1;
                     else if (code == cfg.code_center) filter[c][1] = 1'b1;
                     else if (code == cfg.code_right) filter[c][2] = 1'b1;
                     dec_phase[c] = PH_LEADER_LOW;
                     done = 1'b1;
                  end else begin
                     dec_phase[c] = PH_MARK;
                  end
               end
            end
         endcase
      end while (again);
   endfunction

   // Apply one transaction to the model and return the response it causes.
   function automatic beacon_status_type step_decoder(input logic [1:0] kind,
                                                      input logic [1:0] ch,
                                                      input logic [15:0] stamp);
      beacon_status_type s;
      logic [32:0]       w;
      int                c;
      s = '0;
      c = int'(ch);
      case (kind)
         REQ_EDGE: begin
            ovf_seen[c]  = 2'd0;
            fall_next[c] = ~fall_next[c];
            if (stamp >= last_stamp[c]) w = {17'd0, stamp - last_stamp[c]};
            else w = {17'd0, CAPTURE_ONES - last_stamp[c]} + {17'd0, stamp};
            // The very first capture of a channel only stores its time.
            if (dec_phase[c] == PH_LEADER_LOW && last_stamp[c] == 16'd0) begin
               last_stamp[c] = stamp;
            end else begin
               last_stamp[c] = stamp;
               decode_pulse(c, w, s.code_valid, s.code_value);
            end
         end
         REQ_OVERFLOW: begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (ovf_seen[i] < OVERFLOW_LIMIT) begin
                  ovf_seen[i] = ovf_seen[i] + 2'd1;
                  if (ovf_seen[i] == OVERFLOW_LIMIT) begin
                     fall_next[i] = 1'b1;
                     dec_phase[i] = PH_LEADER_LOW;
                     presence[i]  = 3'd0;
                     filter[i]    = 3'd0;
                  end
               end
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < NUM_CH; i++) begin
               for (int j = 0; j < SITES; j++) begin
                  if (presence[i][j]) begin
                     hold_cnt[i*SITES+j] = hold_cnt[i*SITES+j] + 16'd1;
                     if (hold_cnt[i*SITES+j] >= cfg.hold_ticks) begin
                        hold_cnt[i*SITES+j] = 16'd0;
                        presence[i][j] = 1'b0;
                     end
                  end else begin
                     hold_cnt[i*SITES+j] = 16'd0;
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_CH; i++) begin
         s.flags[i*SITES +: SITES] = presence[i];
         s.wait_fall[i] = fall_next[i];
      end
      return s;
   endfunction

   // Count a mismatch and print a bounded number of them.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Send one request transaction; starts and ends at a falling edge. Valid
   // is left high so that a following request can go out without a gap.
   task automatic send_item(input logic [1:0] kind, input logic [1:0] ch,
                            input logic [15:0] stamp, input logic fixed = 1'b0,
                            input beacon_status_type want = '0);
      beacon_status_type s;
      while (idle_on && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_channel      <= ch;
      req_capture_time <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      s = step_decoder(kind, ch, stamp);
      beacon_status_q.push_back(fixed ? want : s);
      if (kind == REQ_EDGE) chan_now[ch] = stamp;
      if (kind != REQ_UNUSED) sent_items++;
      @(negedge clock);
   endtask

   // Edge on a channel a given width after its previous stimulus edge.
   task automatic send_edge(input int c, input int unsigned w);
      send_item(REQ_EDGE, c[1:0], chan_now[c] + w[15:0]);
   endtask

   // Stray activity: random-time edges, odd widths, ticks, overflows, unused codes.
   task automatic send_noise();
      case ($urandom_range(0, 4))
         0: send_item(REQ_EDGE, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
         1: send_edge($urandom_range(0, NUM_CH - 1), $urandom_range(0, 1500));
         2: send_item(REQ_UNUSED, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
         3: send_item(REQ_OVERFLOW, 2'($urandom_range(0, 3)),
                      16'($urandom_range(0, 65535)));
         default: send_item(REQ_TICK, 2'($urandom_range(0, 3)),
                            16'($urandom_range(0, 65535)));
      endcase
   endtask

   // One NEC frame on a channel, mostly well formed, sometimes broken.
   task automatic send_frame(input int c);
      logic [7:0]  value;
      int unsigned mark;
      int unsigned bit_len;
      if ($urandom_range(0, 1)) send_edge(c, $urandom_range(5001, 30000));
      send_edge(c, $urandom_range(701, 1099));
      send_edge(c, $urandom_range(314, 599));
      case ($urandom_range(0, 4))
         0: value = cfg.code_left;
         1: value = cfg.code_center;
         2: value = cfg.code_right;
         default: value = 8'($urandom_range(0, 255));
      endcase
      for (int i = 7; i >= 0; i--) begin
         mark = $urandom_range(11, 92);
         bit_len = value[i] ? $urandom_range(206, 244) : $urandom_range(93, 131);
         if ($urandom_range(0, 99) < 4) mark = $urandom_range(0, 1500);
         if ($urandom_range(0, 99) < 3) bit_len = mark + $urandom_range(0, 1500);
         if ($urandom_range(0, 99) < 8) send_noise();
         send_edge(c, mark);
         send_edge(c, bit_len - mark);
      end
      // A trailing gap latches the filter into the presence flags.
      if ($urandom_range(0, 1)) send_edge(c, $urandom_range(5001, 30000));
   endtask

   // Random traffic until a number of requests has gone out.
   task automatic run_random(input int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = sent_items + quota;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_frame($urandom_range(0, NUM_CH - 1));
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 12))
               send_item(REQ_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
         end else if (pick < 85) begin
            repeat (2) send_item(REQ_OVERFLOW, 2'($urandom_range(0, 3)),
                                 16'($urandom_range(0, 65535)));
         end else begin
            send_noise();
         end
      end
   endtask

   // Wait until every response is back and the pipeline has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      while (beacon_status_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four registers; only called while the block is idle.
   task automatic program_regs(input logic [7:0] left, input logic [7:0] center,
                               input logic [7:0] right, input logic [15:0] hold);
      logic [15:0] data [4];
      data[CSR_CODE_LEFT]   = {8'($urandom_range(0, 255)), left};
      data[CSR_CODE_CENTER] = {8'($urandom_range(0, 255)), center};
      data[CSR_CODE_RIGHT]  = {8'($urandom_range(0, 255)), right};
      data[CSR_HOLD_TICKS]  = hold;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= data[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (i[1:0])
            CSR_CODE_LEFT:   cfg.code_left   = data[i][7:0];
            CSR_CODE_CENTER: cfg.code_center = data[i][7:0];
            CSR_CODE_RIGHT:  cfg.code_right  = data[i][7:0];
            default:         cfg.hold_ticks  = data[i];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Receiver side stalls at random while idling is enabled.
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
   end

   // Compare each response with the oldest pending prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (beacon_status_q.size() == 0) begin
            report_mismatch("response with none pending, flags", rsp_present_flags, 0);
         end else begin
            if (rsp_present_flags !== beacon_status_q[0].flags)
               report_mismatch("present_flags", rsp_present_flags,
                               beacon_status_q[0].flags);
            if (rsp_wait_falling !== beacon_status_q[0].wait_fall)
               report_mismatch("wait_falling", rsp_wait_falling,
                               beacon_status_q[0].wait_fall);
            if (rsp_code_valid !== beacon_status_q[0].code_valid)
               report_mismatch("code_valid", rsp_code_valid,
                               beacon_status_q[0].code_valid);
            if (rsp_code_value !== beacon_status_q[0].code_value)
               report_mismatch("code_value", rsp_code_value,
                               beacon_status_q[0].code_value);
            if (beacon_status_q[0].code_valid) bytes_seen++;
            void'(beacon_status_q.pop_front());
            checked_count++;
         end
      end
   end

   // Main sequence.
   initial begin
      clear_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table with the register defaults.
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].ch, directed_rows[i].stamp,
                   directed_rows[i].fixed, directed_rows[i].want);
      drain();

      // Distinct random codes with a short hold.
      program_regs(8'($urandom_range(0, 85)), 8'($urandom_range(86, 170)),
                   8'($urandom_range(171, 255)), 16'd4);
      run_random(170);
      drain();

      // Code extremes, left and right equal, shortest hold.
      program_regs(8'h00, 8'hFF, 8'h00, 16'd1);
      run_random(160);
      drain();

      // All sites share one code, longest hold, no idling on either side.
      idle_on = 1'b0;
      program_regs(8'hA5, 8'hA5, 8'hA5, 16'hFFFF);
      run_random(150);
      drain();
      idle_on = 1'b1;

      // Fully random codes and a moderate hold.
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(2, 60)));
      run_random(170);
      drain();

      $display("Sent %0d requests over %0d register settings.", sent_items,
               settings_count);
      $display("Checked %0d responses, %0d with a completed beacon byte, %0d mismatches.",
               checked_count, bytes_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ir_beacon_pulse_decoder verification clean");
      end else begin
         $display("ir_beacon_pulse_decoder verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(2_000_000);
      $display("ir_beacon_pulse_decoder verification failed");
      $finish;
   end

endmodule
